// ===== src/triangle_depth_order_core_defines.svh =====
// ----------------------------------------------------------------------------
// triangle_depth_order_core_defines
// Assertion macros shared by the depth order core.
// ----------------------------------------------------------------------------
`ifndef TRIANGLE_DEPTH_ORDER_CORE_DEFINES_SVH
`define TRIANGLE_DEPTH_ORDER_CORE_DEFINES_SVH

// check a consequence in the same cycle
`define TDO_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// check a consequence in the next cycle
`define TDO_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/tdo_pkg.sv =====
// ----------------------------------------------------------------------------
// tdo_pkg
// Types, codes and widths shared by the depth order controller and datapath.
// ----------------------------------------------------------------------------
package tdo_pkg;

    // configuration register indexes
    localparam logic [1:0] CFG_FOCAL = 2'd0;
    localparam logic [1:0] CFG_CX    = 2'd1;
    localparam logic [1:0] CFG_CY    = 2'd2;

    localparam logic [11:0] FOCAL_RST = 12'd250;
    localparam logic [10:0] CX_RST    = 11'd40;
    localparam logic [10:0] CY_RST    = 11'd12;

    // datapath widths
    localparam int DIV_W  = 31;   // dividend and quotient bits
    localparam int DCNT_W = 5;
    localparam int SCR_W  = 20;   // projected coordinate, pixels Q.4
    localparam int WIDE_W = 43;   // cross products and normals
    localparam int LO_W   = 22;   // low part of a split wide operand
    localparam int MUL_W  = 23;   // multiplier operand
    localparam int ACC_W  = 64;

    // datapath operations
    localparam logic [2:0] OP_NOP   = 3'd0;
    localparam logic [2:0] OP_PMUL  = 3'd1;
    localparam logic [2:0] OP_DIVGO = 3'd2;
    localparam logic [2:0] OP_PWR   = 3'd3;
    localparam logic [2:0] OP_LDE   = 3'd4;
    localparam logic [2:0] OP_TEST  = 3'd5;
    localparam logic [2:0] OP_FIN   = 3'd6;
    localparam logic [2:0] OP_BAD   = 3'd7;

    // difference vectors between edge registers (pos minus neg)
    localparam logic [2:0] V01 = 3'd0;
    localparam logic [2:0] V23 = 3'd1;
    localparam logic [2:0] V02 = 3'd2;
    localparam logic [2:0] V12 = 3'd3;
    localparam logic [2:0] V13 = 3'd4;
    localparam logic [2:0] V10 = 3'd5;

    localparam logic [1:0] C_X = 2'd0;
    localparam logic [1:0] C_Y = 2'd1;
    localparam logic [1:0] C_Z = 2'd2;

    localparam logic [3:0] CODE_PLANE = 4'd9;

    typedef struct packed {
        logic       store;
        logic [2:0] op;
        logic [2:0] idx;
        logic [1:0] sel;
        logic       raw;
        logic       mac;
        logic [2:0] a_vec;
        logic [1:0] a_comp;
        logic       b_wide;
        logic [2:0] b_vec;
        logic [1:0] b_comp;
        logic       b_hi;
        logic       neg;
        logic       clr;
        logic       save;
        logic [1:0] save_idx;
        logic [3:0] code;
    } cmd_t;

    typedef struct packed {
        logic any_bad;
        logic div_done;
        logic hit;
    } status_t;

endpackage

// ===== src/triangle_depth_order_core.sv =====
// ----------------------------------------------------------------------------
// triangle_depth_order_core
// Stores two triangles vertex by vertex and decides which one lies in front.
//
//   channel   direction  handshake                 word
//   vertex    in         start & !busy             slot, vert_x/y/z, run_compare
//   result    out        done (one cycle strobe)   first_in_front, decided_by,
//                                                  bad_depth
//   config    in         cfg_valid & cfg_ready     cfg_index, cfg_data
//
// A vertex without a compare request is only stored. A compare first projects
// all six vertices through the shared divider, then tests edge pairs until one
// decides, or uses the plane test; a depth fault ends it before projecting.
// Reset clears the vertex store and loads the register defaults.
// The result strobe cannot be stalled; cfg_ready is always high.
// ----------------------------------------------------------------------------
module triangle_depth_order_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [2:0]         slot,
    input  logic signed [15:0] vert_x,
    input  logic signed [15:0] vert_y,
    input  logic signed [15:0] vert_z,
    input  logic               run_compare,
    output logic               done,
    output logic               first_in_front,
    output logic [3:0]         decided_by,
    output logic               bad_depth,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [11:0]        cfg_data
);

    tdo_pkg::cmd_t    cmd;
    tdo_pkg::status_t stat;

    assign cfg_ready = 1'b1;

    tdo_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .run_compare (run_compare),
        .busy        (busy),
        .stat        (stat),
        .cmd         (cmd)
    );

    tdo_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .slot           (slot),
        .vert_x         (vert_x),
        .vert_y         (vert_y),
        .vert_z         (vert_z),
        .cfg_valid      (cfg_valid),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .first_in_front (first_in_front),
        .decided_by     (decided_by),
        .bad_depth      (bad_depth),
        .done           (done)
    );

endmodule

// ===== src/tdo_div.sv =====
// ----------------------------------------------------------------------------
// tdo_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tdo_div (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           go,
    input  logic [tdo_pkg::DIV_W-1:0]      dividend,
    input  logic [14:0]                    divisor,
    output logic [tdo_pkg::DIV_W-1:0]      quot,
    output logic                           done
);

    logic [tdo_pkg::DIV_W-1:0]  quo_reg, quo_next;
    logic [14:0]                rem_reg, rem_next;
    logic [14:0]                dvs_reg;
    logic [tdo_pkg::DCNT_W-1:0] cnt_reg, cnt_next;
    logic                       run_reg, run_next;
    logic                       done_reg, done_next;
    logic [15:0]                shifted;
    logic [15:0]                trial;

    // one restoring step
    always_comb
    begin
        shifted   = {rem_reg, quo_reg[tdo_pkg::DIV_W-1]};
        trial     = shifted - {1'b0, dvs_reg};
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        if (go)
        begin
            quo_next = dividend;
            rem_next = '0;
            cnt_next = '0;
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            if (shifted >= {1'b0, dvs_reg})
            begin
                rem_next = trial[14:0];
                quo_next = {quo_reg[tdo_pkg::DIV_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[14:0];
                quo_next = {quo_reg[tdo_pkg::DIV_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == tdo_pkg::DCNT_W'(tdo_pkg::DIV_W - 1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // hold control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // advance payload
    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        if (go)
        begin
            dvs_reg <= divisor;
        end
    end

    assign quot = quo_reg;
    assign done = done_reg;

endmodule

// ===== src/tdo_dp.sv =====
// ----------------------------------------------------------------------------
// tdo_dp
// Datapath: vertex store, projection, shared multiply accumulate, tests.
// ----------------------------------------------------------------------------
module tdo_dp (
    input  logic                  clk,
    input  logic                  rst_n,
    input  tdo_pkg::cmd_t         cmd,
    output tdo_pkg::status_t      stat,
    input  logic [2:0]            slot,
    input  logic signed [15:0]    vert_x,
    input  logic signed [15:0]    vert_y,
    input  logic signed [15:0]    vert_z,
    input  logic                  cfg_valid,
    input  logic [1:0]            cfg_index,
    input  logic [11:0]           cfg_data,
    output logic                  first_in_front,
    output logic [3:0]            decided_by,
    output logic                  bad_depth,
    output logic                  done
);

    localparam int SW = tdo_pkg::SCR_W;
    localparam int WW = tdo_pkg::WIDE_W;
    localparam int MW = tdo_pkg::MUL_W;
    localparam int AW = tdo_pkg::ACC_W;
    localparam int LW = tdo_pkg::LO_W;
    localparam int PW = 2 * tdo_pkg::MUL_W;
    localparam logic signed [33:0] SAT_LO = -34'sd524288;
    localparam logic signed [33:0] SAT_HI = 34'sd524287;

    logic signed [15:0]   vx_reg [6];
    logic signed [15:0]   vy_reg [6];
    logic signed [15:0]   vz_reg [6];
    logic [11:0]          focal_reg;
    logic [10:0]          cx_reg;
    logic [10:0]          cy_reg;
    logic signed [SW-1:0] sx_reg [6];
    logic signed [SW-1:0] sy_reg [6];
    logic signed [SW-1:0] ex_reg [4];
    logic signed [SW-1:0] ey_reg [4];
    logic signed [15:0]   ez_reg [4];
    logic signed [WW-1:0] w_reg [3];
    logic signed [28:0]   prod_reg;
    logic                 sign_reg;
    logic signed [PW-1:0] p_reg;
    logic                 pv_reg, pneg_reg, pclr_reg, phi_reg;
    logic signed [AW-1:0] acc_reg, acc_next;
    logic                 hit_reg;
    logic                 fif_reg, bad_reg, done_reg;
    logic [3:0]           code_reg;

    logic signed [15:0]   rd_x, rd_y, rd_z, coord;
    logic signed [12:0]   focal_s;
    logic signed [28:0]   prod_full;
    logic [28:0]          prod_mag;
    logic [tdo_pkg::DIV_W-1:0] dividend, quot;
    logic                 div_done;
    logic signed [32:0]   qv;
    logic [10:0]          cen;
    logic signed [33:0]   psum;
    logic signed [SW-1:0] psat;
    logic signed [20:0]   dv [6][3];
    logic signed [MW-1:0] a_op, b_op;
    logic signed [WW-1:0] wsel;
    logic signed [AW-1:0] addend;
    logic signed [WW-1:0] nd, nn0, nn1;
    logic                 any_bad, hit_now;

    function automatic logic signed [20:0] sub21(input logic signed [SW-1:0] p,
                                                  input logic signed [SW-1:0] n);
        logic signed [20:0] r;
        r = {p[SW-1], p} - {n[SW-1], n};
        return r;
    endfunction

    function automatic logic signed [20:0] subz(input logic signed [15:0] p,
                                                 input logic signed [15:0] n);
        logic signed [16:0] r;
        r = {p[15], p} - {n[15], n};
        return {{4{r[16]}}, r};
    endfunction

    // read the vertex store at the commanded entry
    assign rd_x = vx_reg[cmd.idx];
    assign rd_y = vy_reg[cmd.idx];
    assign rd_z = vz_reg[cmd.idx];

    // flag any entry with depth not above zero
    always_comb
    begin
        any_bad = 1'b0;
        for (int i = 0; i < 6; i++)
        begin
            if (vz_reg[i] <= 16'sd0)
            begin
                any_bad = 1'b1;
            end
        end
    end

    // projection: scale, divide, offset and clamp
    assign coord     = cmd.sel[0] ? rd_y : rd_x;
    assign focal_s   = $signed({1'b0, focal_reg});
    assign prod_full = coord * focal_s;
    assign prod_mag  = prod_reg[28] ? 29'(-prod_reg) : 29'(prod_reg);
    assign dividend  = {prod_mag[26:0], 4'b0000};
    assign qv        = sign_reg ? -$signed({2'b00, quot}) : $signed({2'b00, quot});
    assign cen       = cmd.sel[0] ? cy_reg : cx_reg;
    assign psum      = {qv[32], qv} + $signed({19'd0, cen, 4'b0000});

    always_comb
    begin
        if (psum < SAT_LO)
        begin
            psat = SAT_LO[SW-1:0];
        end
        else if (psum > SAT_HI)
        begin
            psat = SAT_HI[SW-1:0];
        end
        else
        begin
            psat = psum[SW-1:0];
        end
    end

    tdo_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .go       (cmd.op == tdo_pkg::OP_DIVGO),
        .dividend (dividend),
        .divisor  (rd_z[14:0]),
        .quot     (quot),
        .done     (div_done)
    );

    // difference vectors between edge registers
    always_comb
    begin
        dv[tdo_pkg::V01][0] = sub21(ex_reg[1], ex_reg[0]);
        dv[tdo_pkg::V01][1] = sub21(ey_reg[1], ey_reg[0]);
        dv[tdo_pkg::V01][2] = subz(ez_reg[1], ez_reg[0]);
        dv[tdo_pkg::V23][0] = sub21(ex_reg[3], ex_reg[2]);
        dv[tdo_pkg::V23][1] = sub21(ey_reg[3], ey_reg[2]);
        dv[tdo_pkg::V23][2] = subz(ez_reg[3], ez_reg[2]);
        dv[tdo_pkg::V02][0] = sub21(ex_reg[2], ex_reg[0]);
        dv[tdo_pkg::V02][1] = sub21(ey_reg[2], ey_reg[0]);
        dv[tdo_pkg::V02][2] = subz(ez_reg[2], ez_reg[0]);
        dv[tdo_pkg::V12][0] = sub21(ex_reg[1], ex_reg[2]);
        dv[tdo_pkg::V12][1] = sub21(ey_reg[1], ey_reg[2]);
        dv[tdo_pkg::V12][2] = subz(ez_reg[1], ez_reg[2]);
        dv[tdo_pkg::V13][0] = sub21(ex_reg[1], ex_reg[3]);
        dv[tdo_pkg::V13][1] = sub21(ey_reg[1], ey_reg[3]);
        dv[tdo_pkg::V13][2] = subz(ez_reg[1], ez_reg[3]);
        dv[tdo_pkg::V10][0] = sub21(ex_reg[0], ex_reg[1]);
        dv[tdo_pkg::V10][1] = sub21(ey_reg[0], ey_reg[1]);
        dv[tdo_pkg::V10][2] = subz(ez_reg[0], ez_reg[1]);
    end

    // multiplier operands: a difference, or half of a wide register
    assign wsel = w_reg[cmd.b_comp];

    always_comb
    begin
        a_op = {{(MW-21){dv[cmd.a_vec][cmd.a_comp][20]}}, dv[cmd.a_vec][cmd.a_comp]};
        if (!cmd.b_wide)
        begin
            b_op = {{(MW-21){dv[cmd.b_vec][cmd.b_comp][20]}}, dv[cmd.b_vec][cmd.b_comp]};
        end
        else if (cmd.b_hi)
        begin
            b_op = {{(MW-(WW-LW)){wsel[WW-1]}}, wsel[WW-1:LW]};
        end
        else
        begin
            b_op = $signed({{(MW-LW){1'b0}}, wsel[LW-1:0]});
        end
    end

    // accumulate the registered product
    always_comb
    begin
        addend = {{(AW-PW){p_reg[PW-1]}}, p_reg};
        if (phi_reg)
        begin
            addend = addend <<< LW;
        end
        acc_next = pclr_reg ? '0 : acc_reg;
        if (pv_reg)
        begin
            acc_next = pneg_reg ? acc_next - addend : acc_next + addend;
        end
    end

    // crossing test with sign normalization
    always_comb
    begin
        nd  = w_reg[0][WW-1] ? -w_reg[0] : w_reg[0];
        nn0 = w_reg[0][WW-1] ? -w_reg[1] : w_reg[1];
        nn1 = w_reg[0][WW-1] ? -w_reg[2] : w_reg[2];
        hit_now = (w_reg[0] != '0) && !nn0[WW-1] && (nn0 <= nd)
                  && !nn1[WW-1] && (nn1 <= nd);
    end

    // hold control and stored state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 6; i++)
            begin
                vx_reg[i] <= '0;
                vy_reg[i] <= '0;
                vz_reg[i] <= '0;
            end
            focal_reg <= tdo_pkg::FOCAL_RST;
            cx_reg    <= tdo_pkg::CX_RST;
            cy_reg    <= tdo_pkg::CY_RST;
            pv_reg    <= 1'b0;
            pclr_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.store && (slot < 3'd6))
            begin
                vx_reg[slot] <= vert_x;
                vy_reg[slot] <= vert_y;
                vz_reg[slot] <= vert_z;
            end
            if (cfg_valid)
            begin
                case (cfg_index)
                    tdo_pkg::CFG_FOCAL: focal_reg <= cfg_data;
                    tdo_pkg::CFG_CX:    cx_reg    <= cfg_data[10:0];
                    tdo_pkg::CFG_CY:    cy_reg    <= cfg_data[10:0];
                    default:            ;
                endcase
            end
            pv_reg   <= cmd.mac;
            pclr_reg <= cmd.mac && cmd.clr;
            done_reg <= (cmd.op == tdo_pkg::OP_FIN) || (cmd.op == tdo_pkg::OP_BAD);
        end
    end

    // advance payload registers
    always_ff @(posedge clk)
    begin
        p_reg    <= a_op * b_op;
        pneg_reg <= cmd.neg;
        phi_reg  <= cmd.b_wide && cmd.b_hi;
        acc_reg  <= acc_next;
        if (cmd.save)
        begin
            w_reg[cmd.save_idx] <= acc_reg[WW-1:0];
        end
        case (cmd.op)
            tdo_pkg::OP_PMUL:
            begin
                prod_reg <= prod_full;
            end
            tdo_pkg::OP_DIVGO:
            begin
                sign_reg <= prod_reg[28];
            end
            tdo_pkg::OP_PWR:
            begin
                if (cmd.sel[0])
                begin
                    sy_reg[cmd.idx] <= psat;
                end
                else
                begin
                    sx_reg[cmd.idx] <= psat;
                end
            end
            tdo_pkg::OP_LDE:
            begin
                ex_reg[cmd.sel] <= cmd.raw ? {{(SW-16){rd_x[15]}}, rd_x} : sx_reg[cmd.idx];
                ey_reg[cmd.sel] <= cmd.raw ? {{(SW-16){rd_y[15]}}, rd_y} : sy_reg[cmd.idx];
                ez_reg[cmd.sel] <= rd_z;
            end
            tdo_pkg::OP_TEST:
            begin
                w_reg[0] <= nd;
                w_reg[1] <= nn0;
                w_reg[2] <= nn1;
                hit_reg  <= hit_now;
            end
            tdo_pkg::OP_FIN:
            begin
                fif_reg  <= acc_reg[AW-1];
                code_reg <= cmd.code;
                bad_reg  <= 1'b0;
            end
            tdo_pkg::OP_BAD:
            begin
                fif_reg  <= 1'b0;
                code_reg <= '0;
                bad_reg  <= 1'b1;
            end
            default: ;
        endcase
    end

    assign stat.any_bad  = any_bad;
    assign stat.div_done = div_done;
    assign stat.hit      = hit_reg;

    assign first_in_front = fif_reg;
    assign decided_by     = code_reg;
    assign bad_depth      = bad_reg;
    assign done           = done_reg;

endmodule

// ===== src/tdo_ctrl.sv =====
// ----------------------------------------------------------------------------
// tdo_ctrl
// Controller: sequences projection, edge pair tests and plane fallback.
// ----------------------------------------------------------------------------
`include "triangle_depth_order_core_defines.svh"

module tdo_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic              run_compare,
    output logic              busy,
    input  tdo_pkg::status_t  stat,
    output tdo_pkg::cmd_t     cmd
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_CHK   = 3'd1;
    localparam logic [2:0] ST_PMUL  = 3'd2;
    localparam logic [2:0] ST_DIVGO = 3'd3;
    localparam logic [2:0] ST_DIVW  = 3'd4;
    localparam logic [2:0] ST_PWR   = 3'd5;
    localparam logic [2:0] ST_PAIR  = 3'd6;
    localparam logic [2:0] ST_PLANE = 3'd7;

    logic [2:0] state_reg, state_next;
    logic [2:0] vtx_reg, vtx_next;
    logic       axis_reg, axis_next;
    logic [1:0] ea_reg, ea_next;
    logic [1:0] eb_reg, eb_next;
    logic [3:0] pair_reg, pair_next;
    logic [4:0] step_reg, step_next;
    logic [2:0] va, vb, vc, vd;

    function automatic tdo_pkg::cmd_t mac_op(input tdo_pkg::cmd_t c,
                                             input logic [2:0] av, input logic [1:0] ac,
                                             input logic bw, input logic [2:0] bv,
                                             input logic [1:0] bc, input logic bh,
                                             input logic ng, input logic cl);
        tdo_pkg::cmd_t r;
        r        = c;
        r.mac    = 1'b1;
        r.a_vec  = av;
        r.a_comp = ac;
        r.b_wide = bw;
        r.b_vec  = bv;
        r.b_comp = bc;
        r.b_hi   = bh;
        r.neg    = ng;
        r.clr    = cl;
        return r;
    endfunction

    function automatic tdo_pkg::cmd_t lde_op(input tdo_pkg::cmd_t c, input logic [2:0] v,
                                             input logic [1:0] s, input logic rw);
        tdo_pkg::cmd_t r;
        r     = c;
        r.op  = tdo_pkg::OP_LDE;
        r.idx = v;
        r.sel = s;
        r.raw = rw;
        return r;
    endfunction

    function automatic tdo_pkg::cmd_t save_op(input tdo_pkg::cmd_t c, input logic [1:0] k);
        tdo_pkg::cmd_t r;
        r          = c;
        r.save     = 1'b1;
        r.save_idx = k;
        return r;
    endfunction

    // edge end vertices of the current pair
    assign va = {1'b0, ea_reg};
    assign vb = (ea_reg == 2'd2) ? 3'd0 : {1'b0, ea_reg} + 3'd1;
    assign vc = 3'd3 + {1'b0, eb_reg};
    assign vd = (eb_reg == 2'd2) ? 3'd3 : 3'd4 + {1'b0, eb_reg};

    assign busy = (state_reg != ST_IDLE);

    // next state and datapath command
    always_comb
    begin
        state_next = state_reg;
        vtx_next   = vtx_reg;
        axis_next  = axis_reg;
        ea_next    = ea_reg;
        eb_next    = eb_reg;
        pair_next  = pair_reg;
        step_next  = step_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.store = 1'b1;
                    if (run_compare)
                    begin
                        state_next = ST_CHK;
                    end
                end
            end
            ST_CHK:
            begin
                if (stat.any_bad)
                begin
                    cmd.op     = tdo_pkg::OP_BAD;
                    state_next = ST_IDLE;
                end
                else
                begin
                    vtx_next   = '0;
                    axis_next  = 1'b0;
                    state_next = ST_PMUL;
                end
            end
            ST_PMUL:
            begin
                cmd.op     = tdo_pkg::OP_PMUL;
                cmd.idx    = vtx_reg;
                cmd.sel    = {1'b0, axis_reg};
                state_next = ST_DIVGO;
            end
            ST_DIVGO:
            begin
                cmd.op     = tdo_pkg::OP_DIVGO;
                cmd.idx    = vtx_reg;
                state_next = ST_DIVW;
            end
            ST_DIVW:
            begin
                if (stat.div_done)
                begin
                    state_next = ST_PWR;
                end
            end
            ST_PWR:
            begin
                cmd.op  = tdo_pkg::OP_PWR;
                cmd.idx = vtx_reg;
                cmd.sel = {1'b0, axis_reg};
                axis_next = ~axis_reg;
                state_next = ST_PMUL;
                if (axis_reg)
                begin
                    if (vtx_reg == 3'd5)
                    begin
                        ea_next    = '0;
                        eb_next    = '0;
                        pair_next  = '0;
                        step_next  = '0;
                        state_next = ST_PAIR;
                    end
                    else
                    begin
                        vtx_next = vtx_reg + 3'd1;
                    end
                end
            end
            ST_PAIR:
            begin
                step_next = step_reg + 5'd1;
                case (step_reg)
                    5'd0:  cmd = lde_op(cmd, va, 2'd0, 1'b0);
                    5'd1:  cmd = lde_op(cmd, vb, 2'd1, 1'b0);
                    5'd2:  cmd = lde_op(cmd, vc, 2'd2, 1'b0);
                    5'd3:  cmd = lde_op(cmd, vd, 2'd3, 1'b0);
                    // den = d0 x d1
                    5'd4:  cmd = mac_op(cmd, tdo_pkg::V01, tdo_pkg::C_X, 1'b0,
                                        tdo_pkg::V23, tdo_pkg::C_Y, 1'b0, 1'b0, 1'b1);
                    5'd5:  cmd = mac_op(cmd, tdo_pkg::V01, tdo_pkg::C_Y, 1'b0,
                                        tdo_pkg::V23, tdo_pkg::C_X, 1'b0, 1'b1, 1'b0);
                    // n0 = e x d1
                    5'd6:  cmd = mac_op(cmd, tdo_pkg::V02, tdo_pkg::C_X, 1'b0,
                                        tdo_pkg::V23, tdo_pkg::C_Y, 1'b0, 1'b0, 1'b1);
                    5'd7:
                    begin
                        cmd = mac_op(cmd, tdo_pkg::V02, tdo_pkg::C_Y, 1'b0,
                                     tdo_pkg::V23, tdo_pkg::C_X, 1'b0, 1'b1, 1'b0);
                        cmd = save_op(cmd, 2'd0);
                    end
                    // n1 = e x d0
                    5'd8:  cmd = mac_op(cmd, tdo_pkg::V02, tdo_pkg::C_X, 1'b0,
                                        tdo_pkg::V01, tdo_pkg::C_Y, 1'b0, 1'b0, 1'b1);
                    5'd9:
                    begin
                        cmd = mac_op(cmd, tdo_pkg::V02, tdo_pkg::C_Y, 1'b0,
                                     tdo_pkg::V01, tdo_pkg::C_X, 1'b0, 1'b1, 1'b0);
                        cmd = save_op(cmd, 2'd1);
                    end
                    5'd11: cmd = save_op(cmd, 2'd2);
                    5'd12: cmd.op = tdo_pkg::OP_TEST;
                    5'd13:
                    begin
                        if (!stat.hit)
                        begin
                            step_next = '0;
                            if (pair_reg == 4'd8)
                            begin
                                state_next = ST_PLANE;
                            end
                            else
                            begin
                                pair_next = pair_reg + 4'd1;
                                if (ea_reg == 2'd2)
                                begin
                                    ea_next = '0;
                                    eb_next = eb_reg + 2'd1;
                                end
                                else
                                begin
                                    ea_next = ea_reg + 2'd1;
                                end
                            end
                        end
                    end
                    // (za-zc)*den + (zb-za)*n0 - (zd-zc)*n1, wide terms in halves
                    5'd14: cmd = mac_op(cmd, tdo_pkg::V02, tdo_pkg::C_Z, 1'b1,
                                        3'd0, 2'd0, 1'b1, 1'b1, 1'b1);
                    5'd15: cmd = mac_op(cmd, tdo_pkg::V02, tdo_pkg::C_Z, 1'b1,
                                        3'd0, 2'd0, 1'b0, 1'b1, 1'b0);
                    5'd16: cmd = mac_op(cmd, tdo_pkg::V01, tdo_pkg::C_Z, 1'b1,
                                        3'd0, 2'd1, 1'b1, 1'b0, 1'b0);
                    5'd17: cmd = mac_op(cmd, tdo_pkg::V01, tdo_pkg::C_Z, 1'b1,
                                        3'd0, 2'd1, 1'b0, 1'b0, 1'b0);
                    5'd18: cmd = mac_op(cmd, tdo_pkg::V23, tdo_pkg::C_Z, 1'b1,
                                        3'd0, 2'd2, 1'b1, 1'b1, 1'b0);
                    5'd19: cmd = mac_op(cmd, tdo_pkg::V23, tdo_pkg::C_Z, 1'b1,
                                        3'd0, 2'd2, 1'b0, 1'b1, 1'b0);
                    5'd21:
                    begin
                        cmd.op     = tdo_pkg::OP_FIN;
                        cmd.code   = pair_reg;
                        state_next = ST_IDLE;
                    end
                    default: ;
                endcase
            end
            ST_PLANE:
            begin
                step_next = step_reg + 5'd1;
                case (step_reg)
                    5'd0:  cmd = lde_op(cmd, 3'd0, 2'd0, 1'b1);
                    5'd1:  cmd = lde_op(cmd, 3'd3, 2'd1, 1'b1);
                    5'd2:  cmd = lde_op(cmd, 3'd4, 2'd2, 1'b1);
                    5'd3:  cmd = lde_op(cmd, 3'd5, 2'd3, 1'b1);
                    // normal = (p3-p4) x (p3-p5)
                    5'd4:  cmd = mac_op(cmd, tdo_pkg::V12, tdo_pkg::C_Y, 1'b0,
                                        tdo_pkg::V13, tdo_pkg::C_Z, 1'b0, 1'b0, 1'b1);
                    5'd5:  cmd = mac_op(cmd, tdo_pkg::V12, tdo_pkg::C_Z, 1'b0,
                                        tdo_pkg::V13, tdo_pkg::C_Y, 1'b0, 1'b1, 1'b0);
                    5'd6:  cmd = mac_op(cmd, tdo_pkg::V12, tdo_pkg::C_Z, 1'b0,
                                        tdo_pkg::V13, tdo_pkg::C_X, 1'b0, 1'b0, 1'b1);
                    5'd7:
                    begin
                        cmd = mac_op(cmd, tdo_pkg::V12, tdo_pkg::C_X, 1'b0,
                                     tdo_pkg::V13, tdo_pkg::C_Z, 1'b0, 1'b1, 1'b0);
                        cmd = save_op(cmd, 2'd0);
                    end
                    5'd8:  cmd = mac_op(cmd, tdo_pkg::V12, tdo_pkg::C_X, 1'b0,
                                        tdo_pkg::V13, tdo_pkg::C_Y, 1'b0, 1'b0, 1'b1);
                    5'd9:
                    begin
                        cmd = mac_op(cmd, tdo_pkg::V12, tdo_pkg::C_Y, 1'b0,
                                     tdo_pkg::V13, tdo_pkg::C_X, 1'b0, 1'b1, 1'b0);
                        cmd = save_op(cmd, 2'd1);
                    end
                    5'd11: cmd = save_op(cmd, 2'd2);
                    // dot of (p0-p3) with the normal, wide terms in halves
                    5'd12: cmd = mac_op(cmd, tdo_pkg::V10, tdo_pkg::C_X, 1'b1,
                                        3'd0, 2'd0, 1'b1, 1'b0, 1'b1);
                    5'd13: cmd = mac_op(cmd, tdo_pkg::V10, tdo_pkg::C_X, 1'b1,
                                        3'd0, 2'd0, 1'b0, 1'b0, 1'b0);
                    5'd14: cmd = mac_op(cmd, tdo_pkg::V10, tdo_pkg::C_Y, 1'b1,
                                        3'd0, 2'd1, 1'b1, 1'b0, 1'b0);
                    5'd15: cmd = mac_op(cmd, tdo_pkg::V10, tdo_pkg::C_Y, 1'b1,
                                        3'd0, 2'd1, 1'b0, 1'b0, 1'b0);
                    5'd16: cmd = mac_op(cmd, tdo_pkg::V10, tdo_pkg::C_Z, 1'b1,
                                        3'd0, 2'd2, 1'b1, 1'b0, 1'b0);
                    5'd17: cmd = mac_op(cmd, tdo_pkg::V10, tdo_pkg::C_Z, 1'b1,
                                        3'd0, 2'd2, 1'b0, 1'b0, 1'b0);
                    5'd19:
                    begin
                        cmd.op     = tdo_pkg::OP_FIN;
                        cmd.code   = tdo_pkg::CODE_PLANE;
                        state_next = ST_IDLE;
                    end
                    default: ;
                endcase
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // hold state and counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            vtx_reg   <= '0;
            axis_reg  <= 1'b0;
            ea_reg    <= '0;
            eb_reg    <= '0;
            pair_reg  <= '0;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            vtx_reg   <= vtx_next;
            axis_reg  <= axis_next;
            ea_reg    <= ea_next;
            eb_reg    <= eb_next;
            pair_reg  <= pair_next;
            step_reg  <= step_next;
        end
    end

    `TDO_ASSERT_NXT(a_idle_hold, (state_reg == ST_IDLE) && !(start && run_compare), state_reg == ST_IDLE, "compare began without a request")
    `TDO_ASSERT_IMP(a_div_wait, stat.div_done, state_reg == ST_DIVW, "divider finished outside its wait")
    `TDO_ASSERT_NXT(a_end_idle, (cmd.op == tdo_pkg::OP_FIN) || (cmd.op == tdo_pkg::OP_BAD), state_reg == ST_IDLE, "result word not followed by idle")

endmodule
